[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros for the RTL, included by the accumulator top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock, quiet during reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with the consequent checked in the following cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/spta_pkg.sv]
// ----------------------------------------------------------------------------
// spta_pkg
// Types and constants for the sparse polynomial term accumulator.
// ----------------------------------------------------------------------------
package spta_pkg;

    localparam int TERM_SLOTS     = 32;
    localparam int COEF_FRAC_BITS = 16;
    localparam int CW             = 32;
    localparam int EW             = 16;
    localparam int NW             = $clog2(TERM_SLOTS + 1);
    localparam int IW             = $clog2(TERM_SLOTS);

    localparam logic [2:0] CMD_CLR_ACC  = 3'd0;
    localparam logic [2:0] CMD_INS_ACC  = 3'd1;
    localparam logic [2:0] CMD_CLR_MULT = 3'd2;
    localparam logic [2:0] CMD_INS_MULT = 3'd3;
    localparam logic [2:0] CMD_MAC      = 3'd4;
    localparam logic [2:0] CMD_READ     = 3'd5;

    // broadcast to every cell of a table
    typedef struct packed {
        logic                  load;    // take in the new term
        logic                  add;     // add to the matching cell
        logic                  del;     // matching cell leaves, above shift down
        logic                  clr;
        logic                  rot;     // shift one place towards the head
        logic signed [CW-1:0]  coef;
        logic signed [EW-1:0]  exp;
        logic signed [CW-1:0]  sum;
    } spta_bcast_t;

    function automatic logic signed [CW-1:0] sat_add(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b
    );
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        if (s[CW] != s[CW-1])
            sat_add = s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        else
            sat_add = s[CW-1:0];
        return sat_add;
    endfunction

    function automatic logic add_ovf(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b
    );
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        add_ovf = (s[CW] != s[CW-1]);
        return add_ovf;
    endfunction

endpackage

[rtl/spta_cell.sv]
// ----------------------------------------------------------------------------
// spta_cell
// One slot of a sorted term table. Holds a term, compares it with the
// broadcast term and takes its neighbour's term on shifts.
// ----------------------------------------------------------------------------
module spta_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  spta_pkg::spta_bcast_t            bc,
    input  logic                             prev_valid,
    input  logic                             prev_gt,
    input  logic signed [spta_pkg::CW-1:0]   prev_coef,
    input  logic signed [spta_pkg::EW-1:0]   prev_exp,
    input  logic                             nxt_valid,
    input  logic signed [spta_pkg::CW-1:0]   nxt_coef,
    input  logic signed [spta_pkg::EW-1:0]   nxt_exp,
    input  logic                             nxt_match_or_above,
    output logic                             valid,
    output logic                             gt,
    output logic                             match,
    output logic                             above,
    output logic signed [spta_pkg::CW-1:0]   coef,
    output logic signed [spta_pkg::EW-1:0]   exp
);

    logic                           valid_reg, valid_next;
    logic signed [spta_pkg::CW-1:0] coef_reg, coef_next;
    logic signed [spta_pkg::EW-1:0] exp_reg, exp_next;

    assign valid = valid_reg;
    assign coef  = coef_reg;
    assign exp   = exp_reg;
    assign gt    = valid_reg && (exp_reg > bc.exp);
    assign match = valid_reg && (exp_reg == bc.exp);
    // this cell is at or after the match position (delete shifts it down)
    assign above = match || nxt_match_or_above;

    always_comb
    begin
        valid_next = valid_reg;
        coef_next  = coef_reg;
        exp_next   = exp_reg;
        if (bc.clr)
        begin
            valid_next = 1'b0;
        end
        else if (bc.rot)
        begin
            // last valid cell takes the broadcast head term
            if (nxt_valid)
            begin
                coef_next = nxt_coef;
                exp_next  = nxt_exp;
            end
            else if (valid_reg)
            begin
                coef_next = bc.coef;
                exp_next  = bc.exp;
            end
        end
        else if (bc.add)
        begin
            if (match)
                coef_next = bc.sum;
        end
        else if (bc.del)
        begin
            if (above)
            begin
                valid_next = nxt_valid;
                coef_next  = nxt_coef;
                exp_next   = nxt_exp;
            end
        end
        else if (bc.load)
        begin
            // prev_gt: all cells before are larger; insert here or shift up
            if (prev_gt && !gt)
            begin
                valid_next = 1'b1;
                coef_next  = bc.coef;
                exp_next   = bc.exp;
            end
            else if (!prev_gt)
            begin
                valid_next = prev_valid;
                coef_next  = prev_coef;
                exp_next   = prev_exp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
        exp_reg  <= exp_next;
    end

endmodule

[rtl/spta_table.sv]
// ----------------------------------------------------------------------------
// spta_table
// Row of term cells kept in descending exponent order, head at slot 0.
// ----------------------------------------------------------------------------
module spta_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  spta_pkg::spta_bcast_t            bc,
    output logic                             any_match,
    output logic signed [spta_pkg::CW-1:0]   match_coef,
    output logic                             full,
    output logic [spta_pkg::NW-1:0]          count,
    output logic                             head_valid,
    output logic signed [spta_pkg::CW-1:0]   head_coef,
    output logic signed [spta_pkg::EW-1:0]   head_exp
);

    localparam int N = spta_pkg::TERM_SLOTS;

    logic [N-1:0]                   v, g, m, ab;
    logic signed [spta_pkg::CW-1:0] c [N];
    logic signed [spta_pkg::EW-1:0] e [N];

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        spta_cell u_cell (
            .clk                (clk),
            .rst_n              (rst_n),
            .bc                 (bc),
            .prev_valid         ((k == 0) ? 1'b1 : v[(k == 0) ? 0 : k-1]),
            .prev_gt            ((k == 0) ? 1'b1 : g[(k == 0) ? 0 : k-1]),
            .prev_coef          (c[(k == 0) ? 0 : k-1]),
            .prev_exp           (e[(k == 0) ? 0 : k-1]),
            .nxt_valid          ((k == N-1) ? 1'b0 : v[(k == N-1) ? k : k+1]),
            .nxt_coef           (c[(k == N-1) ? k : k+1]),
            .nxt_exp            (e[(k == N-1) ? k : k+1]),
            .nxt_match_or_above ((k == 0) ? 1'b0 : ab[(k == 0) ? 0 : k-1]),
            .valid              (v[k]),
            .gt                 (g[k]),
            .match              (m[k]),
            .above              (ab[k]),
            .coef               (c[k]),
            .exp                (e[k])
        );
    end

    assign any_match  = |m;
    assign full       = v[N-1];
    assign head_valid = v[0];
    assign head_coef  = c[0];
    assign head_exp   = e[0];

    always_comb
    begin
        match_coef = '0;
        for (int k = 0; k < N; k++)
            if (m[k])
                match_coef = c[k];
    end

    always_comb
    begin
        count = '0;
        for (int k = 0; k < N; k++)
            count = count + spta_pkg::NW'(v[k]);
    end

endmodule

[rtl/sparse_poly_term_accumulator.sv]
// ----------------------------------------------------------------------------
// sparse_poly_term_accumulator
// Two sorted term tables built as rows of cells, with a sequencer for
// clear, insert, multiply-accumulate and read-out.
//
//  channel | signals                                      | dir
//  in      | in_valid in_ready command term_coef term_exp | in
//  out     | out_valid out_ready out_coef out_exp ...     | out
//
// Clear: result hand-off only; insert: compare, then write, then hand-off.
// Multiply-accumulate: per multiplicand term multiply, clip, compare,
//   write and rotate, the multiplicand row rotating once round.
// Read-out: a read and a rotate step per term, the read waiting for a free
//   out register, one result per term, the accumulator row rotating as it goes.
// Reset clears both term counts; the input is held off while a command runs
//   and while the out register still holds an unread result.
// ----------------------------------------------------------------------------
module sparse_poly_term_accumulator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [2:0]                       command,
    input  logic signed [spta_pkg::CW-1:0]   term_coef,
    input  logic signed [spta_pkg::EW-1:0]   term_exp,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [spta_pkg::CW-1:0]   out_coef,
    output logic signed [spta_pkg::EW-1:0]   out_exp,
    output logic [5:0]                       term_count,
    output logic                             is_last,
    output logic                             is_empty,
    output logic                             overflow,
    output logic                             saturated
);

    `include "assert_macros.svh"

    localparam int CW = spta_pkg::CW;
    localparam int EW = spta_pkg::EW;
    localparam int NW = spta_pkg::NW;
    localparam int FB = spta_pkg::COEF_FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_CMP, S_INS_WR, S_MAC_MUL, S_MAC_CLIP, S_MAC_CMP,
        S_MAC_WR, S_MAC_ROT, S_READ, S_RD_ROT, S_RESP
    } state_t;

    state_t                 state_reg;
    logic signed [CW-1:0]   coef_reg, tcoef_reg;
    logic signed [EW-1:0]   exp_reg, texp_reg;
    logic signed [2*CW-1:0] prod_reg;
    logic [NW-1:0]          left_reg;
    logic                   ovf_reg, sat_reg;
    logic                   tgt_mult_reg;

    logic                   ov_valid_reg;
    logic signed [CW-1:0]   ov_coef_reg;
    logic signed [EW-1:0]   ov_exp_reg;
    logic [5:0]             ov_cnt_reg;
    logic                   ov_last_reg, ov_empty_reg, ov_ovf_reg, ov_sat_reg;

    spta_pkg::spta_bcast_t  bc_acc, bc_mul;
    logic                   a_match, m_match, a_full, m_full, a_hv, m_hv;
    logic signed [CW-1:0]   a_mc, m_mc, a_hc, m_hc;
    logic signed [EW-1:0]   a_he, m_he;
    logic [NW-1:0]          a_cnt, m_cnt;

    spta_table u_acc (
        .clk(clk), .rst_n(rst_n), .bc(bc_acc),
        .any_match(a_match), .match_coef(a_mc), .full(a_full), .count(a_cnt),
        .head_valid(a_hv), .head_coef(a_hc), .head_exp(a_he)
    );

    spta_table u_mul (
        .clk(clk), .rst_n(rst_n), .bc(bc_mul),
        .any_match(m_match), .match_coef(m_mc), .full(m_full), .count(m_cnt),
        .head_valid(m_hv), .head_coef(m_hc), .head_exp(m_he)
    );

    logic                   out_free;
    logic                   ov_load;
    logic                   t_match, t_full;
    logic signed [CW-1:0]   t_mc;
    logic signed [CW-1:0]   ins_sum;
    logic                   ins_sovf;
    logic signed [2*CW-1:0] rnd;
    logic signed [2*CW-FB-1:0] shf;
    logic signed [CW-1:0]   clip;
    logic                   clip_sat;

    assign out_free = !ov_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign ov_load  = ((state_reg == S_READ) || (state_reg == S_RESP)) && out_free;

    assign t_match  = tgt_mult_reg ? m_match : a_match;
    assign t_full   = tgt_mult_reg ? m_full : a_full;
    assign t_mc     = tgt_mult_reg ? m_mc : a_mc;
    assign ins_sum  = spta_pkg::sat_add(t_mc, coef_reg);
    assign ins_sovf = spta_pkg::add_ovf(t_mc, coef_reg);

    // round half up then floor shift
    assign rnd = (FB > 0) ? prod_reg + ((2*CW)'(1) <<< ((FB > 0) ? FB-1 : 0)) : prod_reg;
    assign shf = rnd[2*CW-1:FB];
    assign clip_sat = (shf > (2*CW-FB)'(signed'({1'b0, {(CW-1){1'b1}}})))
                   || (shf < -(2*CW-FB)'(signed'({1'b0, {(CW-1){1'b1}}})) - 1);
    assign clip = (shf > (2*CW-FB)'(signed'({1'b0, {(CW-1){1'b1}}}))) ?
                      {1'b0, {(CW-1){1'b1}}} :
                  (shf < -(2*CW-FB)'(signed'({1'b0, {(CW-1){1'b1}}})) - 1) ?
                      {1'b1, {(CW-1){1'b0}}} : shf[CW-1:0];

    always_comb
    begin
        bc_acc      = '0;
        bc_mul      = '0;
        bc_acc.coef = coef_reg;
        bc_acc.exp  = exp_reg;
        bc_acc.sum  = ins_sum;
        bc_mul.coef = coef_reg;
        bc_mul.exp  = exp_reg;
        bc_mul.sum  = ins_sum;
        case (state_reg)
            S_INS_WR, S_MAC_WR:
            begin
                if (coef_reg != '0)
                begin
                    if (t_match)
                    begin
                        if (ins_sum == '0)
                        begin
                            bc_acc.del = !tgt_mult_reg;
                            bc_mul.del = tgt_mult_reg;
                        end
                        else
                        begin
                            bc_acc.add = !tgt_mult_reg;
                            bc_mul.add = tgt_mult_reg;
                        end
                    end
                    else if (!t_full)
                    begin
                        bc_acc.load = !tgt_mult_reg;
                        bc_mul.load = tgt_mult_reg;
                    end
                end
            end
            S_MAC_ROT:
            begin
                bc_mul.rot  = 1'b1;
                bc_mul.coef = m_hc;
                bc_mul.exp  = m_he;
            end
            S_RD_ROT:
            begin
                bc_acc.rot  = 1'b1;
                bc_acc.coef = a_hc;
                bc_acc.exp  = a_he;
            end
            S_IDLE:
            begin
                bc_acc.clr = in_valid && in_ready && (command == spta_pkg::CMD_CLR_ACC);
                bc_mul.clr = in_valid && in_ready && (command == spta_pkg::CMD_CLR_MULT);
            end
            default: ;
        endcase
    end

    // rotation wraps the head round to the last valid cell, so rotating
    // by the count brings the row back to where it started
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ov_valid_reg <= 1'b0;
            tgt_mult_reg <= 1'b0;
        end
        else
        begin
            if (ov_load)
                ov_valid_reg <= 1'b1;
            else if (out_ready)
                ov_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        coef_reg     <= term_coef;
                        exp_reg      <= term_exp;
                        tcoef_reg    <= term_coef;
                        texp_reg     <= term_exp;
                        ovf_reg      <= 1'b0;
                        sat_reg      <= 1'b0;
                        tgt_mult_reg <= (command == spta_pkg::CMD_INS_MULT);
                        left_reg     <= (command == spta_pkg::CMD_READ) ? a_cnt : m_cnt;
                        case (command)
                            spta_pkg::CMD_INS_ACC,
                            spta_pkg::CMD_INS_MULT: state_reg <= S_INS_CMP;
                            spta_pkg::CMD_MAC:      state_reg <= S_MAC_MUL;
                            spta_pkg::CMD_READ:     state_reg <= S_READ;
                            default:                state_reg <= S_RESP;
                        endcase
                    end
                end
                S_INS_CMP: state_reg <= S_INS_WR;
                S_INS_WR, S_MAC_WR:
                begin
                    if (coef_reg != '0)
                    begin
                        if (t_match)
                            sat_reg <= sat_reg | ins_sovf;
                        else if (t_full)
                            ovf_reg <= 1'b1;
                    end
                    state_reg <= (state_reg == S_MAC_WR) ? S_MAC_ROT : S_RESP;
                end
                S_MAC_MUL:
                begin
                    if (left_reg == '0)
                        state_reg <= S_RESP;
                    else
                    begin
                        prod_reg  <= tcoef_reg * m_hc;
                        exp_reg   <= texp_reg + m_he;
                        state_reg <= S_MAC_CLIP;
                    end
                end
                S_MAC_CLIP:
                begin
                    coef_reg  <= clip;
                    sat_reg   <= sat_reg | clip_sat;
                    state_reg <= S_MAC_CMP;
                end
                S_MAC_CMP: state_reg <= S_MAC_WR;
                S_MAC_ROT:
                begin
                    left_reg  <= left_reg - NW'(1);
                    state_reg <= S_MAC_MUL;
                end
                S_READ:
                begin
                    if (out_free)
                    begin
                        ov_cnt_reg   <= 6'(a_cnt);
                        ov_ovf_reg   <= 1'b0;
                        ov_sat_reg   <= 1'b0;
                        if (left_reg == '0)
                        begin
                            ov_coef_reg  <= '0;
                            ov_exp_reg   <= '0;
                            ov_last_reg  <= 1'b1;
                            ov_empty_reg <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                        else
                        begin
                            ov_coef_reg  <= a_hc;
                            ov_exp_reg   <= a_he;
                            ov_last_reg  <= (left_reg == NW'(1));
                            ov_empty_reg <= 1'b0;
                            state_reg    <= S_RD_ROT;
                        end
                    end
                end
                S_RD_ROT:
                begin
                    left_reg  <= left_reg - NW'(1);
                    state_reg <= (left_reg == NW'(1)) ? S_IDLE : S_READ;
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        ov_coef_reg  <= '0;
                        ov_exp_reg   <= '0;
                        ov_cnt_reg   <= 6'(a_cnt);
                        ov_last_reg  <= 1'b1;
                        ov_empty_reg <= 1'b0;
                        ov_ovf_reg   <= ovf_reg;
                        ov_sat_reg   <= sat_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid  = ov_valid_reg;
    assign out_coef   = ov_coef_reg;
    assign out_exp    = ov_exp_reg;
    assign term_count = ov_cnt_reg;
    assign is_last    = ov_last_reg;
    assign is_empty   = ov_empty_reg;
    assign overflow   = ov_ovf_reg;
    assign saturated  = ov_sat_reg;

    `CHK_IMPL(a_rdy_idle, clk, rst_n, in_ready, state_reg == S_IDLE, "ready outside idle")
    `CHK_IMPL(a_empty_last, clk, rst_n, out_valid && is_empty, is_last && out_coef == '0,
        "empty result not final")
    `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result lost")

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sparse polynomial term accumulator: directed
// items, then random polynomial build / multiply / read-out sequences, checked
// result by result against a behavioural model of both term tables.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]           cmd;
        logic signed [31:0]   coef;
        logic signed [15:0]   exp;
    } cmd_item_t;

    typedef struct packed {
        logic signed [31:0]   coef;
        logic signed [15:0]   exp;
        logic [5:0]           cnt;
        logic                 last;
        logic                 empty;
        logic                 ovf;
        logic                 sat;
    } term_res_t;

    localparam int CMD_UNUSED_A = 6;
    localparam int CMD_UNUSED_B = 7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] command = '0;
    logic signed [31:0] term_coef = '0;
    logic signed [15:0] term_exp = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] out_coef;
    logic signed [15:0] out_exp;
    logic [5:0] term_count;
    logic is_last, is_empty, overflow, saturated;

    sparse_poly_term_accumulator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .term_coef(term_coef), .term_exp(term_exp),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_coef(out_coef), .out_exp(out_exp), .term_count(term_count),
        .is_last(is_last), .is_empty(is_empty), .overflow(overflow),
        .saturated(saturated)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // model state
    logic signed [31:0] acc_c [spta_pkg::TERM_SLOTS];
    logic signed [15:0] acc_e [spta_pkg::TERM_SLOTS];
    int acc_n;
    logic signed [31:0] mul_c [spta_pkg::TERM_SLOTS];
    logic signed [15:0] mul_e [spta_pkg::TERM_SLOTS];
    int mul_n;
    bit f_ovf, f_sat;

    cmd_item_t pending_q[$];
    term_res_t expected_q[$];
    int errors = 0;
    int sent = 0, results = 0, n_ovf = 0, n_sat = 0, n_reads = 0;
    int send_idle = 0, recv_idle = 0;
    int hold_off = 0;

    function automatic logic signed [31:0] clip(input longint v);
        if (v > 64'sd2147483647)
        begin
            f_sat = 1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            f_sat = 1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    task automatic insert_acc(input logic signed [31:0] c, input logic signed [15:0] e);
        int i;
        logic signed [31:0] s;
        i = 0;
        if (c == 0) return;
        while (i < acc_n && acc_e[i] > e) i++;
        if (i < acc_n && acc_e[i] == e)
        begin
            s = clip(longint'(acc_c[i]) + longint'(c));
            if (s == 0)
            begin
                for (int j = i; j + 1 < acc_n; j++)
                begin
                    acc_c[j] = acc_c[j+1];
                    acc_e[j] = acc_e[j+1];
                end
                acc_n--;
            end
            else
                acc_c[i] = s;
            return;
        end
        if (acc_n >= spta_pkg::TERM_SLOTS)
        begin
            f_ovf = 1;
            return;
        end
        for (int j = acc_n; j > i; j--)
        begin
            acc_c[j] = acc_c[j-1];
            acc_e[j] = acc_e[j-1];
        end
        acc_c[i] = c;
        acc_e[i] = e;
        acc_n++;
    endtask

    task automatic insert_mul(input logic signed [31:0] c, input logic signed [15:0] e);
        int i;
        logic signed [31:0] s;
        i = 0;
        if (c == 0) return;
        while (i < mul_n && mul_e[i] > e) i++;
        if (i < mul_n && mul_e[i] == e)
        begin
            s = clip(longint'(mul_c[i]) + longint'(c));
            if (s == 0)
            begin
                for (int j = i; j + 1 < mul_n; j++)
                begin
                    mul_c[j] = mul_c[j+1];
                    mul_e[j] = mul_e[j+1];
                end
                mul_n--;
            end
            else
                mul_c[i] = s;
            return;
        end
        if (mul_n >= spta_pkg::TERM_SLOTS)
        begin
            f_ovf = 1;
            return;
        end
        for (int j = mul_n; j > i; j--)
        begin
            mul_c[j] = mul_c[j-1];
            mul_e[j] = mul_e[j-1];
        end
        mul_c[i] = c;
        mul_e[i] = e;
        mul_n++;
    endtask

    task automatic predict_terms(input cmd_item_t it);
        term_res_t r;
        longint p;
        logic signed [15:0] pe;
        f_ovf = 0;
        f_sat = 0;
        case (it.cmd)
            spta_pkg::CMD_CLR_ACC: acc_n = 0;
            spta_pkg::CMD_INS_ACC: insert_acc(it.coef, it.exp);
            spta_pkg::CMD_CLR_MULT: mul_n = 0;
            spta_pkg::CMD_INS_MULT: insert_mul(it.coef, it.exp);
            spta_pkg::CMD_MAC:
                for (int i = 0; i < mul_n; i++)
                begin
                    p = longint'(it.coef) * longint'(mul_c[i]);
                    p = p + (64'sd1 <<< (spta_pkg::COEF_FRAC_BITS - 1));
                    p = p >>> spta_pkg::COEF_FRAC_BITS;   // arithmetic shift floors
                    pe = it.exp + mul_e[i];
                    insert_acc(clip(p), pe);
                end
            spta_pkg::CMD_READ:
            begin
                n_reads++;
                if (acc_n == 0)
                begin
                    r = '{coef: 0, exp: 0, cnt: 0, last: 1, empty: 1, ovf: 0, sat: 0};
                    expected_q.push_back(r);
                end
                for (int i = 0; i < acc_n; i++)
                begin
                    r = '{coef: acc_c[i], exp: acc_e[i], cnt: 6'(acc_n),
                          last: (i + 1 == acc_n), empty: 0, ovf: 0, sat: 0};
                    expected_q.push_back(r);
                end
                return;
            end
            default: ;
        endcase
        n_ovf += f_ovf;
        n_sat += f_sat;
        r = '{coef: 0, exp: 0, cnt: 6'(acc_n), last: 1, empty: 0, ovf: f_ovf, sat: f_sat};
        expected_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("tb: mismatch %s got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_terms('{cmd: command, coef: term_coef, exp: term_exp});
                sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    cmd_item_t it;
                    it = pending_q.pop_front();
                    in_valid <= 1'b1;
                    command <= it.cmd;
                    term_coef <= it.coef;
                    term_exp <= it.exp;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                term_res_t w;
                results++;
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result", results, 0);
                else
                begin
                    w = expected_q.pop_front();
                    if (out_coef !== w.coef) report_mismatch("out_coef", out_coef, w.coef);
                    if (out_exp !== w.exp) report_mismatch("out_exp", out_exp, w.exp);
                    if (term_count !== w.cnt) report_mismatch("term_count", term_count, w.cnt);
                    if (is_last !== w.last) report_mismatch("is_last", is_last, w.last);
                    if (is_empty !== w.empty) report_mismatch("is_empty", is_empty, w.empty);
                    if (overflow !== w.ovf) report_mismatch("overflow", overflow, w.ovf);
                    if (saturated !== w.sat) report_mismatch("saturated", saturated, w.sat);
                end
            end
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic cmd_item_t mk(input int c, input logic [31:0] k, input int e);
        cmd_item_t it;
        it.cmd = 3'(c);
        it.coef = k;
        it.exp = 16'(e);
        return it;
    endfunction

    function automatic logic [31:0] rnd_coef();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'sh7fffffff - $urandom_range(3);
            2: return 32'sh80000000 + $urandom_range(3);
            3: return 32'($signed($urandom_range(8)) - 4) <<< 16;
            default: return 32'($signed($urandom_range(200000)) - 100000);
        endcase
    endfunction

    function automatic logic [15:0] rnd_exp();
        if ($urandom_range(4) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(12)) - 6);
    endfunction

    task automatic wait_drained();
        while (pending_q.size() > 0 || in_valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // random polynomial build, multiply, read, clears and unused codes; ends on a read-out
    task automatic queue_sequences(input int n);
        int k;
        k = 0;
        while (k < n)
        begin
            int r;
            r = $urandom_range(99);
            if (r < 8)
            begin
                pending_q.push_back(mk(spta_pkg::CMD_CLR_ACC, $urandom, $urandom));
                k++;
            end
            else if (r < 14)
            begin
                pending_q.push_back(mk(spta_pkg::CMD_CLR_MULT, $urandom, $urandom));
                k++;
            end
            else if (r < 17)
            begin
                pending_q.push_back(mk($urandom_range(CMD_UNUSED_A, CMD_UNUSED_B),
                                       $urandom, $urandom));
                k++;
            end
            else if (r < 25)
            begin
                pending_q.push_back(mk(spta_pkg::CMD_READ, $urandom, $urandom));
                k++;
            end
            else if (r < 50)
            begin
                pending_q.push_back(mk(spta_pkg::CMD_INS_MULT, rnd_coef(), rnd_exp()));
                k++;
            end
            else if (r < 62)
            begin
                pending_q.push_back(mk(spta_pkg::CMD_MAC, rnd_coef(), rnd_exp()));
                k++;
            end
            else
            begin
                pending_q.push_back(mk(spta_pkg::CMD_INS_ACC, rnd_coef(), rnd_exp()));
                k++;
            end
        end
        pending_q.push_back(mk(spta_pkg::CMD_READ, 0, 0));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every command, cancellation, saturation, unused codes
        pending_q.push_back(mk(spta_pkg::CMD_READ, 0, 0));
        pending_q.push_back(mk(spta_pkg::CMD_INS_ACC, 0, 5));
        pending_q.push_back(mk(spta_pkg::CMD_INS_ACC, 32'sh7fffffff, 16'sh7fff));
        pending_q.push_back(mk(spta_pkg::CMD_INS_ACC, 32'sh7fffffff, 16'sh7fff));
        pending_q.push_back(mk(spta_pkg::CMD_INS_ACC, 32'sh80000000, 16'sh8000));
        pending_q.push_back(mk(spta_pkg::CMD_INS_ACC, 32'sh80000000, 16'sh8000));
        pending_q.push_back(mk(spta_pkg::CMD_INS_ACC, 32'sh00010000, 0));
        pending_q.push_back(mk(spta_pkg::CMD_INS_ACC, 32'shffff0000, 0));
        pending_q.push_back(mk(spta_pkg::CMD_READ, 0, 0));
        pending_q.push_back(mk(spta_pkg::CMD_INS_MULT, 32'sh7fffffff, 16'sh7fff));
        pending_q.push_back(mk(spta_pkg::CMD_INS_MULT, 32'sh00000001, 1));
        pending_q.push_back(mk(spta_pkg::CMD_INS_MULT, 32'sh80000000, 16'sh8000));
        pending_q.push_back(mk(spta_pkg::CMD_MAC, 32'sh7fffffff, 16'sh7fff));
        pending_q.push_back(mk(spta_pkg::CMD_MAC, 32'sh00008000, 16'sh8000));
        pending_q.push_back(mk(spta_pkg::CMD_MAC, 32'shffffffff, 3));
        pending_q.push_back(mk(spta_pkg::CMD_READ, 0, 0));
        pending_q.push_back(mk(CMD_UNUSED_A, 32'hffffffff, 16'hffff));
        pending_q.push_back(mk(CMD_UNUSED_B, 0, 0));
        pending_q.push_back(mk(spta_pkg::CMD_CLR_MULT, 0, 0));
        pending_q.push_back(mk(spta_pkg::CMD_MAC, 32'sh00010000, 0));
        pending_q.push_back(mk(spta_pkg::CMD_CLR_ACC, 32'hffffffff, 16'hffff));
        pending_q.push_back(mk(spta_pkg::CMD_READ, 0, 0));
        wait_drained();

        // full tables: 34 distinct exponents, then merge into a full table, then 33 multiplicand terms
        for (int i = 0; i < 34; i++)
            pending_q.push_back(mk(spta_pkg::CMD_INS_ACC, 32'sh00020000, 16'(i * 7 - 100)));
        pending_q.push_back(mk(spta_pkg::CMD_INS_ACC, 32'sh00010000, 16'(-100)));
        for (int i = 0; i < 33; i++)
            pending_q.push_back(mk(spta_pkg::CMD_INS_MULT, 32'sh00010000 + i, 16'(i)));
        pending_q.push_back(mk(spta_pkg::CMD_READ, 0, 0));
        pending_q.push_back(mk(spta_pkg::CMD_MAC, 32'sh00010000, 1000));
        pending_q.push_back(mk(spta_pkg::CMD_CLR_ACC, 0, 0));
        pending_q.push_back(mk(spta_pkg::CMD_CLR_MULT, 0, 0));
        // long receiver hold-off while the sender keeps offering
        hold_off = 400;
        wait_drained();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = (ph == 1 || ph == 3) ? 84 : 0;
            recv_idle = (ph == 2) ? 84 : (ph == 3) ? 6 : 0;
            if (ph == 3) send_idle = 6;
            queue_sequences(70);
            if (ph == 2) hold_off = 300;
            wait_drained();
        end

        $display("tb: %0d items sent, %0d results checked, %0d read-outs", sent, results, n_reads);
        $display("tb: %0d overflow and %0d saturation statuses seen", n_ovf, n_sat);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("tb: FAIL");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/spta_pkg.sv
rtl/spta_cell.sv
rtl/spta_table.sv
rtl/sparse_poly_term_accumulator.sv
tb/tb.sv
